### sv/h2s_pkg.sv
package h2s_pkg;

  localparam int CODE_W = 8;               // sRGB code width
  localparam int KEY_W  = 15;              // half magnitude bits (sign dropped)
  localparam int HALF_W = 16;
  localparam int STAGES = CODE_W;          // one search stage per code bit
  localparam int BIT_W  = $clog2(CODE_W);
  localparam int CODES  = 1 << CODE_W;

  // Half patterns at or above 1.0 always give full scale.
  localparam logic [KEY_W-1:0] ONE_KEY = 15'h3C00;
  localparam logic [4:0]       EXP_MAX = 5'h1F;

  // Curve constants, scaled to integers.
  localparam logic [63:0] LIN_LIMIT = 64'd31308;     // 0.0031308 * 1e7
  localparam logic [63:0] LIN_SCALE = 64'd10000000;
  localparam logic [63:0] LIN_GAIN  = 64'd32946;     // 12.92 * 255 * 10
  localparam logic [319:0] ROOT_DEN = 320'd10761;

  typedef logic [CODES-1:0][KEY_W-1:0] thr_table_t;

  typedef struct packed {
    logic [STAGES-1:0] load;   // lane stage register enables
    logic              out_load;
  } h2s_ctl_t;

  // True when a positive finite half (below 1.0) encodes to code k or above.
  // Power segment uses exact integer form of 255*(1.055*x^(5/12)-0.055) >= k-1/2.
  function automatic logic reaches(input logic [KEY_W-1:0] h, input logic [CODE_W-1:0] k);
    logic [4:0]   e;
    logic [10:0]  m;
    logic [4:0]   sh;
    logic [63:0]  v;
    logic [63:0]  d;
    logic [319:0] lhs;
    logic [319:0] rhs;
    logic [319:0] a;
    logic [8:0]   amt;
    e = h[14:10];
    if (h >= ONE_KEY) begin
      return 1'b1;
    end
    if (e == 5'd0) begin
      m  = {1'b0, h[9:0]};
      sh = 5'd24;
    end else begin
      m  = {1'b1, h[9:0]};
      sh = 5'd25 - e;
    end
    if (64'(m) * LIN_SCALE <= (LIN_LIMIT << sh)) begin
      v = 64'(m) * LIN_GAIN;
      d = 64'd10 << sh;
      return (v + (d >> 1)) >= 64'(k) * d;
    end
    lhs = 320'd1;
    for (int i = 0; i < 5; i++) begin
      lhs = lhs * 320'(m);
    end
    for (int i = 0; i < 12; i++) begin
      lhs = lhs * ROOT_DEN;
    end
    a   = 320'(k) * 320'd40 + 320'd541;
    rhs = 320'd1;
    for (int i = 0; i < 12; i++) begin
      rhs = rhs * a;
    end
    amt = 9'(sh) * 9'd5;
    rhs = rhs << amt;
    return lhs >= rhs;
  endfunction

  // Smallest half magnitude that reaches each code; entry 0 unused.
  function automatic thr_table_t build_thresholds();
    thr_table_t       t;
    logic [KEY_W-1:0] lo;
    logic [KEY_W-1:0] hi;
    logic [KEY_W-1:0] mid;
    t = '0;
    for (int k = 1; k < CODES; k++) begin
      lo = 15'd1;
      hi = ONE_KEY;
      while (lo < hi) begin
        mid = KEY_W'((16'(lo) + 16'(hi)) >> 1);
        if (reaches(mid, CODE_W'(k))) begin
          hi = mid;
        end else begin
          lo = mid + 15'd1;
        end
      end
      t[k] = lo;
    end
    return t;
  endfunction

  localparam thr_table_t THRESH = build_thresholds();

  // One binary-search step: try setting bit b of the code.
  function automatic logic [CODE_W-1:0] decide(input logic [KEY_W-1:0]  key,
                                               input logic [CODE_W-1:0] code,
                                               input logic [BIT_W-1:0]  b);
    logic [CODE_W-1:0] cand;
    cand = code | (CODE_W'(1) << b);
    return (key >= THRESH[cand]) ? cand : code;
  endfunction

endpackage

### sv/half_to_srgb8_encoder.sv
// Linear-light to 8-bit sRGB encoder. Each request is one texel of three
// IEEE binary16 channels (alpha not carried); each result is three sRGB codes,
// clamped to [0,1], linear below 0.0031308 and 1.055*x^(1/2.4)-0.055 above,
// scaled by 255 and rounded half away from zero. Negatives, zero and NaN give
// 0; one and above and +inf give 255. The block takes one texel per clock when
// the output is not stalled: every channel has its own lane that finds the code
// by an 8-step binary search over a 255-entry threshold table, one code bit per
// pipeline stage, and the output register merges the three lanes. Stalls on the
// output side fill empty stages first, so texel_ready drops only when all nine
// registers hold requests. The thresholds are derived at elaboration from exact
// integer forms of the curve, so every one of the 65536 half inputs gets the
// code that the exact curve gives.
module half_to_srgb8_encoder (
  input  logic        clk,
  input  logic        rst,
  // texel request
  input  logic        texel_valid,
  output logic        texel_ready,
  input  logic [15:0] red_half,
  input  logic [15:0] green_half,
  input  logic [15:0] blue_half,
  // encoded result
  output logic        code_valid,
  input  logic        code_ready,
  output logic [7:0]  red_code,
  output logic [7:0]  green_code,
  output logic [7:0]  blue_code
);

  h2s_pkg::h2s_ctl_t           ctl;
  logic [h2s_pkg::CODE_W-1:0]  red_lane;
  logic [h2s_pkg::CODE_W-1:0]  green_lane;
  logic [h2s_pkg::CODE_W-1:0]  blue_lane;

  // Valid tracking and per-stage load enables, shared by all lanes.
  h2s_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .texel_valid (texel_valid),
    .texel_ready (texel_ready),
    .code_valid  (code_valid),
    .code_ready  (code_ready),
    .ctl         (ctl)
  );

  // One search lane per channel; they step in lockstep.
  h2s_lane u_lane_red (
    .clk  (clk),
    .half (red_half),
    .ctl  (ctl),
    .code (red_lane)
  );

  h2s_lane u_lane_green (
    .clk  (clk),
    .half (green_half),
    .ctl  (ctl),
    .code (green_lane)
  );

  h2s_lane u_lane_blue (
    .clk  (clk),
    .half (blue_half),
    .ctl  (ctl),
    .code (blue_lane)
  );

  // Merge: output register collects the three lane codes of one texel.
  // Payload only, validity lives in the control block.
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      red_code   <= red_lane;
      green_code <= green_lane;
      blue_code  <= blue_lane;
    end
  end

endmodule

### sv/h2s_lane.sv
module h2s_lane (
  input  logic                              clk,
  input  logic [h2s_pkg::HALF_W-1:0]        half,
  input  h2s_pkg::h2s_ctl_t                 ctl,
  output logic [h2s_pkg::CODE_W-1:0]        code
);

  localparam int STAGES = h2s_pkg::STAGES;

  logic [h2s_pkg::KEY_W-1:0]  key_dec;
  logic                       nan_in;
  logic [h2s_pkg::KEY_W-1:0]  key_q   [STAGES-1];
  logic [h2s_pkg::CODE_W-1:0] code_q  [STAGES];
  logic [h2s_pkg::KEY_W-1:0]  key_at  [STAGES];
  logic [h2s_pkg::CODE_W-1:0] code_at [STAGES];
  logic [h2s_pkg::CODE_W-1:0] code_nx [STAGES];

  // negatives and NaN map to key 0 (below every threshold)
  assign nan_in  = (half[14:10] == h2s_pkg::EXP_MAX) && (half[9:0] != 10'd0);
  assign key_dec = (half[15] || nan_in) ? '0 : half[14:0];

  always_comb begin
    key_at[0]  = key_dec;
    code_at[0] = '0;
    for (int s = 1; s < STAGES; s++) begin
      key_at[s]  = key_q[s-1];
      code_at[s] = code_q[s-1];
    end
    for (int s = 0; s < STAGES; s++) begin
      code_nx[s] = h2s_pkg::decide(key_at[s], code_at[s],
                                   h2s_pkg::BIT_W'(STAGES - 1 - s));
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < STAGES; s++) begin
      if (ctl.load[s]) begin
        code_q[s] <= code_nx[s];
      end
    end
    for (int s = 0; s < STAGES - 1; s++) begin
      if (ctl.load[s]) begin
        key_q[s] <= key_at[s];
      end
    end
  end

  assign code = code_q[STAGES-1];

endmodule

### sv/h2s_ctrl.sv
module h2s_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              texel_valid,
  output logic              texel_ready,
  output logic              code_valid,
  input  logic              code_ready,
  output h2s_pkg::h2s_ctl_t ctl
);

  localparam int STAGES = h2s_pkg::STAGES;

  logic [STAGES-1:0] stage_valid;
  logic [STAGES-1:0] valid_src;
  logic [STAGES:0]   can;

  assign valid_src = {stage_valid[STAGES-2:0], texel_valid};

  // a stage can take new data if empty or its successor moves on
  always_comb begin
    can[STAGES] = !code_valid || code_ready;
    for (int j = 0; j < STAGES; j++) begin
      can[STAGES-1-j] = !stage_valid[STAGES-1-j] || can[STAGES-j];
    end
  end

  always_comb begin
    for (int s = 0; s < STAGES; s++) begin
      ctl.load[s] = valid_src[s] && can[s];
    end
    ctl.out_load = stage_valid[STAGES-1] && can[STAGES];
  end

  assign texel_ready = can[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      code_valid  <= 1'b0;
    end else begin
      for (int s = 0; s < STAGES; s++) begin
        if (can[s]) begin
          stage_valid[s] <= valid_src[s];
        end
      end
      if (can[STAGES]) begin
        code_valid <= stage_valid[STAGES-1];
      end
    end
  end

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !texel_ready |-> (&stage_valid) && code_valid && !code_ready)
    else $error("input stalled with a free stage");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    code_valid && code_ready |=> code_valid == $past(stage_valid[STAGES-1]))
    else $error("output register did not refill from last stage");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |=> code_valid)
    else $error("output load lost");

  a_conserve: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> $countones({stage_valid, code_valid}) ==
      $countones($past({stage_valid, code_valid}))
      + $countones($past(texel_valid && texel_ready))
      - $countones($past(code_valid && code_ready)))
    else $error("request count in pipeline not conserved");

  a_reset: assert property (@(posedge clk)
    rst |=> !code_valid && (stage_valid == '0))
    else $error("pipeline not empty after reset");

endmodule

### sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQS = 1880;  // random requests after the directed table
  localparam int CALM_REQS   = 300;   // tail of the run with no idling at all
  localparam int LONG_HOLD   = 80;    // cycles the receiver holds off once
  localparam int HOLD_AT     = 500;   // accepted requests before the long hold
  localparam int TAIL_CYCLES = 32;    // settle time after the last result

  typedef logic [h2s_pkg::HALF_W-1:0] half_t;
  typedef logic [h2s_pkg::CODE_W-1:0] code_t;

  typedef struct packed {
    code_t red;
    code_t green;
    code_t blue;
  } texel_codes_t;

  // One directed request. When known is set, the codes are typed in and the
  // predictor is bypassed for that request.
  typedef struct packed {
    logic  known;
    half_t red;
    half_t green;
    half_t blue;
    code_t want_r;
    code_t want_g;
    code_t want_b;
  } direct_row_t;

  localparam int DIRECT_ROWS = 15;
  localparam direct_row_t DIRECT [DIRECT_ROWS] = '{
    // zero everywhere
    '{1'b1, 16'h0000, 16'h0000, 16'h0000, 8'd0,   8'd0,   8'd0},
    // exactly one
    '{1'b1, 16'h3C00, 16'h3C00, 16'h3C00, 8'd255, 8'd255, 8'd255},
    // +inf, -inf, quiet NaN
    '{1'b1, 16'h7C00, 16'hFC00, 16'h7E00, 8'd255, 8'd0,   8'd0},
    // negative zero, negative NaN, all ones (NaN)
    '{1'b1, 16'h8000, 16'hFE00, 16'hFFFF, 8'd0,   8'd0,   8'd0},
    // largest finite, most negative finite, signaling NaN
    '{1'b1, 16'h7BFF, 16'hFBFF, 16'h7C01, 8'd255, 8'd0,   8'd0},
    // above one: 2.0, 8192, next after one
    '{1'b1, 16'h4000, 16'h7000, 16'h3C01, 8'd255, 8'd255, 8'd255},
    // small negatives and -1.0
    '{1'b1, 16'h8001, 16'h83FF, 16'hBC00, 8'd0,   8'd0,   8'd0},
    // smallest and largest subnormal, smallest normal
    '{1'b0, 16'h0001, 16'h03FF, 16'h0400, 8'd0,   8'd0,   8'd0},
    // either side of the linear/power knee
    '{1'b0, 16'h1A68, 16'h1A69, 16'h1A6A, 8'd0,   8'd0,   8'd0},
    '{1'b0, 16'h1A6B, 16'h1A6C, 16'h1A70, 8'd0,   8'd0,   8'd0},
    // mid-range values
    '{1'b0, 16'h3800, 16'h3400, 16'h31C3, 8'd0,   8'd0,   8'd0},
    // just below one
    '{1'b0, 16'h3BFF, 16'h3BFE, 16'h3BF0, 8'd0,   8'd0,   8'd0},
    // alternating bit patterns
    '{1'b0, 16'h5555, 16'hAAAA, 16'h2AAA, 8'd0,   8'd0,   8'd0},
    // NaN with all mantissa bits, mid power segment, mid subnormal
    '{1'b0, 16'h7FFF, 16'h3A00, 16'h0200, 8'd0,   8'd0,   8'd0},
    // deep in the linear segment
    '{1'b0, 16'h1000, 16'h0800, 16'h1400, 8'd0,   8'd0,   8'd0}
  };

  logic  clk = 1'b0;
  logic  rst = 1'b1;

  logic  texel_valid = 1'b0;
  logic  texel_ready;
  half_t red_half    = '0;
  half_t green_half  = '0;
  half_t blue_half   = '0;

  logic  code_valid;
  logic  code_ready  = 1'b0;
  code_t red_code;
  code_t green_code;
  code_t blue_code;

  // Typed-in expectation travelling with the request on the input side.
  logic  row_known  = 1'b0;
  code_t row_want_r = '0;
  code_t row_want_g = '0;
  code_t row_want_b = '0;

  texel_codes_t codes_due[$];
  int   errors     = 0;
  int   texels_in  = 0;
  bit   calm       = 1'b0;  // set for the tail: no idling on either side
  bit   rx_holding = 1'b0;  // receiver is in its long hold-off

  half_to_srgb8_encoder dut (
    .clk        (clk),
    .rst        (rst),
    .texel_valid(texel_valid),
    .texel_ready(texel_ready),
    .red_half   (red_half),
    .green_half (green_half),
    .blue_half  (blue_half),
    .code_valid (code_valid),
    .code_ready (code_ready),
    .red_code   (red_code),
    .green_code (green_code),
    .blue_code  (blue_code)
  );

  initial begin
    forever begin
      #2 clk = ~clk;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor: exact integer form of the sRGB transfer curve.
  // A finite positive half below one is x = m / 2^sh, m < 2048.
  // ---------------------------------------------------------------------

  // True when 255*(1.055*x^(5/12) - 0.055) >= k - 1/2, in the form
  // m^5 * 10761^12 >= (40k + 541)^12 * 2^(5*sh).
  function automatic bit curve_reaches(input logic [319:0] lhs, input int k,
                                       input int sh);
    logic [319:0] rhs;
    logic [319:0] base;
    rhs  = 320'd1;
    base = 320'(40 * k + 541);
    for (int i = 0; i < 12; i++) begin
      rhs = rhs * base;
    end
    rhs = rhs << (5 * sh);
    return lhs >= rhs;
  endfunction

  function automatic code_t srgb_code_of(input half_t h);
    logic         neg;
    logic [4:0]   expo;
    logic [9:0]   frac;
    logic [10:0]  m;
    int           sh;
    logic [63:0]  num;
    logic [63:0]  den;
    logic [319:0] lhs;
    int           lo;
    int           hi;
    int           mid;
    neg  = h[15];
    expo = h[14:10];
    frac = h[9:0];
    // infinities and NaN: only +inf saturates high
    if (expo == 5'h1F) begin
      return (frac == '0 && !neg) ? code_t'(255) : code_t'(0);
    end
    if (neg) begin
      return '0;
    end
    if (expo == 5'd0 && frac == '0) begin
      return '0;
    end
    if (expo >= 5'd15) begin
      return code_t'(255);
    end
    if (expo == 5'd0) begin
      m  = {1'b0, frac};
      sh = 24;
    end else begin
      m  = {1'b1, frac};
      sh = 25 - int'(expo);
    end
    // linear segment: round(x * 12.92 * 255), ties away from zero
    if (64'(m) * 64'd10000000 <= (64'd31308 << sh)) begin
      num = 64'(m) * 64'd32946;
      den = 64'd10 << sh;
      return code_t'((num + (den >> 1)) / den);
    end
    lhs = 320'd1;
    for (int i = 0; i < 5; i++) begin
      lhs = lhs * 320'(m);
    end
    for (int i = 0; i < 12; i++) begin
      lhs = lhs * 320'd10761;
    end
    // largest k in 0..255 that the curve reaches
    lo = 0;
    hi = 255;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (curve_reaches(lhs, mid, sh)) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return code_t'(lo);
  endfunction

  // Random channel value, weighted toward the interesting parts of the curve.
  function automatic half_t pick_half();
    int sel;
    sel = $urandom_range(0, 15);
    case (sel)
      0, 1, 2, 3, 4, 5: begin
        return {1'b0, 5'($urandom_range(0, 14)), 10'($urandom)};
      end
      6, 7, 8: begin
        return half_t'($urandom);
      end
      9: begin
        return 16'h1A00 + half_t'($urandom_range(0, 255));
      end
      10: begin
        // specials: inf/NaN of either sign, signed zero
        if ($urandom_range(0, 1) == 0) begin
          return {1'($urandom), 5'h1F, 10'($urandom_range(0, 3) == 0 ? 0 : $urandom)};
        end
        return {1'($urandom), 15'h0000};
      end
      11: begin
        return {6'b000000, 10'($urandom)};
      end
      12: begin
        return {1'b0, 5'($urandom_range(15, 30)), 10'($urandom)};
      end
      default: begin
        // top of the code range
        return {1'b0, 5'd14, 10'($urandom)};
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d at %0t ns", what, got, want, $time);
  endtask

  // ---------------------------------------------------------------------
  // Monitor: predicts on each accepted request, checks each accepted result
  // against the oldest prediction.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    texel_codes_t due;
    texel_codes_t want;
    if (!rst) begin
      if (texel_valid && texel_ready) begin
        if (row_known) begin
          due.red   = row_want_r;
          due.green = row_want_g;
          due.blue  = row_want_b;
        end else begin
          due.red   = srgb_code_of(red_half);
          due.green = srgb_code_of(green_half);
          due.blue  = srgb_code_of(blue_half);
        end
        codes_due.push_back(due);
        texels_in++;
      end
      if (code_valid && code_ready) begin
        if (codes_due.size() == 0) begin
          report_mismatch("result with no request pending",
                          int'({red_code, green_code, blue_code}), -1);
        end else begin
          want = codes_due.pop_front();
          if (red_code !== want.red) begin
            report_mismatch("red_code", int'(red_code), int'(want.red));
          end
          if (green_code !== want.green) begin
            report_mismatch("green_code", int'(green_code), int'(want.green));
          end
          if (blue_code !== want.blue) begin
            report_mismatch("blue_code", int'(blue_code), int'(want.blue));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender side. All input changes happen at the falling edge; valid stays
  // high across back-to-back requests.
  // ---------------------------------------------------------------------
  task automatic offer(input half_t r, input half_t g, input half_t b,
                       input logic known, input texel_codes_t want, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      texel_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    texel_valid <= 1'b1;
    red_half    <= r;
    green_half  <= g;
    blue_half   <= b;
    row_known   <= known;
    row_want_r  <= want.red;
    row_want_g  <= want.green;
    row_want_b  <= want.blue;
    @(posedge clk);
    while (!texel_ready) @(posedge clk);
  endtask

  // Drop valid and wait for every outstanding result.
  task automatic drain();
    @(negedge clk);
    texel_valid <= 1'b0;
    while (codes_due.size() != 0) @(posedge clk);
  endtask

  function automatic int sender_gap(input int rate);
    if (calm || rx_holding || rate == 0) begin
      return 0;
    end
    if ($urandom_range(1, rate) != 1) begin
      return 0;
    end
    return $urandom_range(1, 17);
  endfunction

  initial begin : sender
    texel_codes_t want;
    int           rate;
    @(negedge clk);
    while (rst) @(negedge clk);

    // directed table, idling still random
    rate = 4;
    for (int i = 0; i < DIRECT_ROWS; i++) begin
      want.red   = DIRECT[i].want_r;
      want.green = DIRECT[i].want_g;
      want.blue  = DIRECT[i].want_b;
      offer(DIRECT[i].red, DIRECT[i].green, DIRECT[i].blue, DIRECT[i].known,
            want, sender_gap(rate));
    end
    drain();

    want = '0;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      // idle density changes every 64 requests, including stretches with none
      if (n % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       rate = 0;
          1:       rate = 3;
          default: rate = 10;
        endcase
      end
      // pause once midway until the pipeline is completely empty
      if (n == RANDOM_REQS / 2) begin
        drain();
      end
      if (n >= RANDOM_REQS - CALM_REQS) begin
        calm = 1'b1;
      end
      offer(pick_half(), pick_half(), pick_half(), 1'b0, want, sender_gap(rate));
    end
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("half_to_srgb8_encoder regression: pass");
    end else begin
      $display("half_to_srgb8_encoder regression: fail");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Receiver side: random stall bursts, plus one long hold-off that lets
  // the pipeline fill and back-pressure the input.
  // ---------------------------------------------------------------------
  initial begin : receiver
    int  stall_left;
    int  rate;
    int  cyc;
    bit  long_done;
    stall_left = 0;
    rate       = 0;
    cyc        = 0;
    long_done  = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (cyc % 128 == 0) begin
        case ($urandom_range(0, 2))
          0:       rate = 0;
          1:       rate = 4;
          default: rate = 12;
        endcase
      end
      cyc++;
      if (stall_left > 0) begin
        stall_left--;
        code_ready <= 1'b0;
        if (stall_left == 0) begin
          rx_holding = 1'b0;
        end
      end else if (!long_done && texels_in >= HOLD_AT) begin
        long_done  = 1'b1;
        rx_holding = 1'b1;
        stall_left = LONG_HOLD - 1;
        code_ready <= 1'b0;
      end else if (!calm && rate != 0 && $urandom_range(1, rate) == 1) begin
        stall_left = $urandom_range(0, 16);
        code_ready <= 1'b0;
      end else begin
        code_ready <= 1'b1;
      end
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #2000000;
    $display("half_to_srgb8_encoder regression: fail");
    $finish;
  end

endmodule
